### design/esd_pkg.sv
package esd_pkg;

  localparam logic [7:0] ESC_CODE     = 8'h1B;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [4:0] OCT_BASE     = 5'd8;
  localparam logic [4:0] HEX_BASE     = 5'd16;
  localparam logic [1:0] OCT_DIGITS   = 2'd3;
  localparam logic [1:0] HEX_DIGITS   = 2'd2;
  localparam logic [4:0] NOT_DIGIT    = 5'd31;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    MODE_TEXT   = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_NUMBER = 2'd2
  } scan_mode_t;

  typedef struct packed {
    logic       op;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;
  } out_item_t;

  typedef struct packed {
    scan_mode_t mode;
    logic       number_is_hex;
    logic [1:0] digits_taken;
    logic [7:0] number_value;
  } scan_state_t;

  typedef struct packed {
    scan_state_t          state;
    logic [1:0]           count;
    out_item_t [1:0]      res;
  } decode_t;

  localparam scan_state_t STATE_RESET = '{MODE_TEXT, 1'b0, 2'd0, 8'd0};

  // Digit value of 0-9, a-f, A-F; anything else reads as NOT_DIGIT.
  function automatic logic [4:0] digit_of(input logic [7:0] ch);
    logic [4:0] d;
    d = NOT_DIGIT;
    if (ch >= 8'h30 && ch <= 8'h39) d = 5'(ch - 8'h30);
    else if (ch >= 8'h61 && ch <= 8'h66) d = 5'(ch - 8'h57);
    else if (ch >= 8'h41 && ch <= 8'h46) d = 5'(ch - 8'h37);
    return d;
  endfunction

endpackage

### design/esd_decode.sv
module esd_decode (
  input  esd_pkg::scan_state_t state,
  input  esd_pkg::in_item_t    item,
  output esd_pkg::decode_t     dec
);

  logic [7:0]  ch;
  logic [4:0]  d;
  logic [4:0]  base;
  logic [1:0]  maxd;
  logic [1:0]  digits_inc;
  logic [7:0]  value_inc;
  logic        to_text;

  assign ch = item.text_byte;

  always_comb begin
    d          = esd_pkg::digit_of(ch);
    base       = state.number_is_hex ? esd_pkg::HEX_BASE : esd_pkg::OCT_BASE;
    maxd       = state.number_is_hex ? esd_pkg::HEX_DIGITS : esd_pkg::OCT_DIGITS;
    digits_inc = state.digits_taken + 2'd1;
    value_inc  = state.number_is_hex ? {state.number_value[3:0], d[3:0]}
                                     : {state.number_value[4:0], d[2:0]};
    to_text    = 1'b0;

    dec.state = state;
    dec.count = 2'd0;
    dec.res   = '0;

    if (item.op) begin
      // Flush a pending number; anything else is dropped.
      if (state.mode == esd_pkg::MODE_NUMBER) begin
        dec.count = 2'd1;
        dec.res[0] = '{state.number_value, 1'b1, 1'b1};
      end
      dec.state = esd_pkg::STATE_RESET;
    end else begin
      case (state.mode)
        esd_pkg::MODE_ESCAPE: begin
          dec.state.mode = esd_pkg::MODE_TEXT;
          dec.count = 2'd1;
          dec.res[0] = '{ch, 1'b1, 1'b0};
          case (ch)
            8'h61: dec.res[0].out_byte = 8'h07;            // a
            8'h62: dec.res[0].out_byte = 8'h08;            // b
            8'h65: dec.res[0].out_byte = esd_pkg::ESC_CODE; // e
            8'h66: dec.res[0].out_byte = 8'h0C;            // f
            8'h6E: dec.res[0].out_byte = 8'h0A;            // n
            8'h72: dec.res[0].out_byte = 8'h0D;            // r
            8'h74: dec.res[0].out_byte = 8'h09;            // t
            8'h76: dec.res[0].out_byte = 8'h0B;            // v
            esd_pkg::CH_X: begin
              dec.count = 2'd0;
              dec.state = '{esd_pkg::MODE_NUMBER, 1'b1, 2'd0, 8'd0};
            end
            default: begin
              if (ch inside {[8'h30:8'h37]}) begin
                dec.count = 2'd0;
                dec.state = '{esd_pkg::MODE_NUMBER, 1'b0, 2'd1, {5'd0, ch[2:0]}};
              end
            end
          endcase
        end
        esd_pkg::MODE_NUMBER: begin
          if (d < base) begin
            if (digits_inc >= maxd) begin
              dec.count = 2'd1;
              dec.res[0] = '{value_inc, 1'b1, 1'b0};
              dec.state = esd_pkg::STATE_RESET;
            end else begin
              dec.state.digits_taken = digits_inc;
              dec.state.number_value = value_inc;
            end
          end else begin
            // Emit the value, then treat the byte as normal text.
            dec.count = 2'd1;
            dec.res[0] = '{state.number_value, 1'b1, 1'b0};
            dec.state = esd_pkg::STATE_RESET;
            to_text = 1'b1;
          end
        end
        default: begin
          to_text = 1'b1;
        end
      endcase

      if (to_text) begin
        dec.state.mode = esd_pkg::MODE_TEXT;
        if (ch == esd_pkg::CH_BACKSLASH) begin
          dec.state.mode = esd_pkg::MODE_ESCAPE;
        end else if (dec.count == 2'd1) begin
          dec.res[0].run_last = 1'b0;
          dec.res[1] = '{ch, 1'b1, 1'b0};
          dec.count = 2'd2;
        end else begin
          dec.res[0] = '{ch, 1'b1, 1'b0};
          dec.count = 2'd1;
        end
      end
    end
  end

endmodule

### design/escape_sequence_decoder.sv
// Two register stages (input register, result queue); an accepted item is decoded from the
// input register and its first result is offered from the queue once the item moves on.
// Throughput: one item per cycle while each item's result set fits into the queue; the
// decoder does all work for an item in one pass. A two-result item waits in the input
// register unless the queue is empty once the head leaves; output stalls also hold items.
// Reset (rst, synchronous): scan state returns to normal text, queue and input register empty.
module escape_sequence_decoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 text_valid,
  output logic                 text_stall,
  input  esd_pkg::in_item_t    text_item,
  output logic                 dec_valid,
  input  logic                 dec_stall,
  output esd_pkg::out_item_t   dec_item
);

  // Input register
  logic                 ir_valid;
  esd_pkg::in_item_t    ir_item;

  // Scan state
  esd_pkg::scan_state_t state;

  // Result queue, entry 0 is the head
  esd_pkg::out_item_t [esd_pkg::QUEUE_DEPTH-1:0] q;
  esd_pkg::out_item_t [esd_pkg::QUEUE_DEPTH-1:0] q_next;
  logic [1:0]           cnt;
  logic [1:0]           cnt_next;

  esd_pkg::decode_t     dec;
  logic                 pop;
  logic                 move;
  logic [1:0]           base;
  logic [1:0]           free;

  esd_decode u_decode (
    .state (state),
    .item  (ir_item),
    .dec   (dec)
  );

  assign dec_valid = (cnt != 2'd0);
  assign dec_item  = q[0];
  assign pop       = dec_valid && !dec_stall;

  // Entries still held once the head leaves, and the room that remains.
  assign base = cnt - {1'b0, pop};
  assign free = 2'(esd_pkg::QUEUE_DEPTH) - base;

  // Advance the input register only when its whole result set fits.
  assign move       = ir_valid && (dec.count <= free);
  assign text_stall = ir_valid && !move;

  always_comb begin
    q_next   = q;
    cnt_next = base;
    if (pop) begin
      q_next[0] = q[1];
    end
    if (move) begin
      if (dec.count != 2'd0) begin
        q_next[base[0]] = dec.res[0];
      end
      if (dec.count == 2'd2) begin
        // Two results only fit into an empty queue.
        q_next[1] = dec.res[1];
      end
      cnt_next = base + dec.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
      state    <= esd_pkg::STATE_RESET;
      cnt      <= 2'd0;
    end else begin
      // Load a fresh item, or drop the one that just moved on.
      if (text_valid && !text_stall) begin
        ir_valid <= 1'b1;
      end else if (move) begin
        ir_valid <= 1'b0;
      end
      if (move) begin
        state <= dec.state;
      end
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      ir_item <= text_item;
    end
    q <= q_next;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= 2'(esd_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_ir_hold: assert property (@(posedge clk) disable iff (rst)
    (ir_valid && !move) |=> (ir_valid && ir_item == $past(ir_item)))
    else $error("held item lost or changed");

  a_flush_text: assert property (@(posedge clk) disable iff (rst)
    (move && ir_item.op) |=> (state.mode == esd_pkg::MODE_TEXT))
    else $error("end of text left scan outside normal text");

  a_hex_digits: assert property (@(posedge clk) disable iff (rst)
    (state.mode == esd_pkg::MODE_NUMBER && state.number_is_hex)
      |-> (state.digits_taken < esd_pkg::HEX_DIGITS))
    else $error("hex number held at full length");

  a_oct_digits: assert property (@(posedge clk) disable iff (rst)
    (state.mode == esd_pkg::MODE_NUMBER && !state.number_is_hex)
      |-> (state.digits_taken != 2'd0 && state.digits_taken < esd_pkg::OCT_DIGITS))
    else $error("octal digit count out of range");
`endif

endmodule

### tb/esd_tb_pkg.sv
package esd_tb_pkg;

  // Item kinds on the text channel.
  localparam logic OP_TEXT = 1'b0;
  localparam logic OP_END  = 1'b1;

endpackage

### tb/escape_sequence_decoder_checker.sv
module escape_sequence_decoder_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               text_valid,
  input  logic               text_stall,
  input  esd_pkg::in_item_t  text_item,
  input  logic               dec_valid,
  input  logic               dec_stall,
  input  esd_pkg::out_item_t dec_item,
  output int                 error_count,
  output int                 expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  // Scan state mirrored from the decoder's behaviour.
  esd_pkg::scan_mode_t scan;
  logic       number_hex;
  logic [1:0] digit_count;
  logic [7:0] number_acc;

  esd_pkg::out_item_t expected_bytes[$];

  function automatic void clear_scan();
    scan        = esd_pkg::MODE_TEXT;
    number_hex  = 1'b0;
    digit_count = 2'd0;
    number_acc  = 8'd0;
  endfunction

  function automatic void expect_byte(logic [7:0] b, logic last, logic fin);
    esd_pkg::out_item_t r;
    r.out_byte = b;
    r.run_last = last;
    r.text_end = fin;
    expected_bytes = {expected_bytes, r};
  endfunction

  // Value of a hex or decimal digit character; 99 for anything else.
  function automatic int unsigned digit_value(logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return ch - "0";
    if (ch >= "a" && ch <= "f") return ch - "a" + 10;
    if (ch >= "A" && ch <= "F") return ch - "A" + 10;
    return 99;
  endfunction

  // Work out the bytes one text item yields and queue them.
  function automatic void decode_char(esd_pkg::in_item_t it);
    logic [7:0]  ch;
    logic [7:0]  ended_value;
    bit          number_ended;
    int unsigned base;
    int unsigned digit_limit;
    int unsigned d;
    ch           = it.text_byte;
    number_ended = 1'b0;
    ended_value  = 8'd0;
    if (it.op == esd_tb_pkg::OP_END) begin
      if (scan == esd_pkg::MODE_NUMBER) expect_byte(number_acc, 1'b1, 1'b1);
      clear_scan();
      return;
    end
    if (scan == esd_pkg::MODE_ESCAPE) begin
      scan = esd_pkg::MODE_TEXT;
      case (ch)
        "a": expect_byte(8'h07, 1'b1, 1'b0);
        "b": expect_byte(8'h08, 1'b1, 1'b0);
        "e": expect_byte(esd_pkg::ESC_CODE, 1'b1, 1'b0);
        "f": expect_byte(8'h0C, 1'b1, 1'b0);
        "n": expect_byte(8'h0A, 1'b1, 1'b0);
        "r": expect_byte(8'h0D, 1'b1, 1'b0);
        "t": expect_byte(8'h09, 1'b1, 1'b0);
        "v": expect_byte(8'h0B, 1'b1, 1'b0);
        esd_pkg::CH_X: begin
          scan        = esd_pkg::MODE_NUMBER;
          number_hex  = 1'b1;
          digit_count = 2'd0;
          number_acc  = 8'd0;
        end
        default: begin
          if (ch >= "0" && ch <= "7") begin
            scan        = esd_pkg::MODE_NUMBER;
            number_hex  = 1'b0;
            digit_count = 2'd1;
            number_acc  = ch - "0";
          end else begin
            expect_byte(ch, 1'b1, 1'b0);
          end
        end
      endcase
      return;
    end
    if (scan == esd_pkg::MODE_NUMBER) begin
      base        = number_hex ? 16 : 8;
      digit_limit = number_hex ? 2 : 3;
      d           = digit_value(ch);
      if (d < base) begin
        number_acc  = 8'(number_acc * base + d);
        digit_count = digit_count + 2'd1;
        if (digit_count >= digit_limit) begin
          expect_byte(number_acc, 1'b1, 1'b0);
          clear_scan();
        end
        return;
      end
      // a non-digit closes the number, then falls through as plain text
      number_ended = 1'b1;
      ended_value  = number_acc;
      clear_scan();
    end
    scan = esd_pkg::MODE_TEXT;
    if (ch == esd_pkg::CH_BACKSLASH) begin
      if (number_ended) expect_byte(ended_value, 1'b1, 1'b0);
      scan = esd_pkg::MODE_ESCAPE;
      return;
    end
    if (number_ended) expect_byte(ended_value, 1'b0, 1'b0);
    expect_byte(ch, 1'b1, 1'b0);
  endfunction

  always @(posedge clk) begin
    esd_pkg::out_item_t want;
    if (rst) begin
      clear_scan();
      expected_bytes.delete();
      error_count   <= 0;
      expected_left <= 0;
    end else begin
      // results leave after the input register, so check before predicting
      if (dec_valid && !dec_stall) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result, expected none, got byte %h last %b end %b",
                   $time, dec_item.out_byte, dec_item.run_last, dec_item.text_end);
          error_count <= error_count + 1;
        end else begin
          want = expected_bytes.pop_front();
          if (dec_item !== want) begin
            // fields shown as byte/last/end
            $display("%0t: result mismatch, expected %h/%b/%b, got %h/%b/%b",
                     $time, want.out_byte, want.run_last, want.text_end,
                     dec_item.out_byte, dec_item.run_last, dec_item.text_end);
            error_count <= error_count + 1;
          end
        end
      end
      if (text_valid && !text_stall) decode_char(text_item);
      expected_left <= expected_bytes.size();
    end
  end

endmodule

### tb/escape_sequence_decoder_tb.sv
module escape_sequence_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET  = 1700;
  // Generous bound on the run length; a clean run stays far below it.
  localparam int LIMIT_CYCLES = 200000;

  logic               clk;
  logic               rst;
  logic               text_valid;
  logic               text_stall;
  esd_pkg::in_item_t  text_item;
  logic               dec_valid;
  logic               dec_stall;
  esd_pkg::out_item_t dec_item;

  int error_count;
  int expected_left;
  int items_sent;
  int cycle_no = 0;
  bit tail;          // last stretch of the run: no idling on either side
  int stall_left;

  string LETTER_ESCAPES = "abefnrtv";
  string HEX_CHARS      = "0123456789abcdefABCDEF";

  escape_sequence_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_item  (text_item),
    .dec_valid  (dec_valid),
    .dec_stall  (dec_stall),
    .dec_item   (dec_item)
  );

  escape_sequence_decoder_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .text_valid    (text_valid),
    .text_stall    (text_stall),
    .text_item     (text_item),
    .dec_valid     (dec_valid),
    .dec_stall     (dec_stall),
    .dec_item      (dec_item),
    .error_count   (error_count),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_no <= cycle_no + 1;

  // Abandon a run that hangs.
  initial begin
    wait (cycle_no >= LIMIT_CYCLES);
    $display("escape_sequence_decoder_tb: done, errors");
    $finish;
  end

  // Receiver: stall in random bursts, with quiet stretches between
  // phases and none at all in the tail.
  initial begin
    dec_stall  <= 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        dec_stall  <= 1'b1;
        stall_left = stall_left - 1;
      end else if (!tail && ((cycle_no / 300) % 4 != 3) && $urandom_range(0, 4) == 0) begin
        dec_stall  <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        dec_stall <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] octal_char();
    return 8'("0" + $urandom_range(0, 7));
  endfunction

  // Offer one item at the falling edge and hold it until the decoder takes it.
  // Occasionally idle first, except in quiet stretches.
  task automatic send_item(input logic code, input logic [7:0] ch);
    esd_pkg::in_item_t it;
    it.op        = code;
    it.text_byte = ch;
    if (!tail && ((items_sent / 128) % 3 != 2) && $urandom_range(0, 3) == 0) begin
      text_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    text_valid <= 1'b1;
    text_item  <= it;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    @(negedge clk);
    items_sent = items_sent + 1;
    tail       = (items_sent >= ITEM_TARGET - 150);
  endtask

  task automatic send_text(input logic [7:0] ch);
    send_item(esd_tb_pkg::OP_TEXT, ch);
  endtask

  // The byte carried by an end-of-text item is ignored; randomise it anyway.
  task automatic send_end();
    send_item(esd_tb_pkg::OP_END, any_byte());
  endtask

  task automatic send_escape(input logic [7:0] ch);
    send_text(esd_pkg::CH_BACKSLASH);
    send_text(ch);
  endtask

  initial begin
    int unsigned pick;
    logic [7:0]  b;
    items_sent = 0;
    tail       = 1'b0;
    rst        <= 1'b1;
    text_valid <= 1'b0;
    text_item  <= '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes, then each corner of the escape grammar.
    send_text(8'hFF);
    send_text(8'h01);
    send_escape("e");
    // hex cut short by a non-digit: value first, then the byte itself
    send_escape(esd_pkg::CH_X);
    send_text("4");
    send_text("g");
    // three octal digits complete the number; 0777 wraps to 0xFF
    send_escape("7");
    send_text("7");
    send_text("7");
    // an 8 is not octal: close the number and pass the 8 through
    send_escape("1");
    send_text("8");
    send_escape("9");
    // hex with no digits at end of text flushes zero
    send_escape(esd_pkg::CH_X);
    send_end();
    // number closed by a backslash, then a dangling backslash dropped by the flush
    send_escape("5");
    send_text(esd_pkg::CH_BACKSLASH);
    send_end();
    // flush in plain text gives nothing
    send_end();

    // Random: mostly well-formed escapes with random content, plus noise.
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        b = any_byte();
        if (b == esd_pkg::CH_BACKSLASH) b = b + 8'd1;
        send_text(b);
      end else if (pick < 40) begin
        send_escape(LETTER_ESCAPES[$urandom_range(0, 7)]);
      end else if (pick < 56) begin
        send_escape(octal_char());
        repeat ($urandom_range(0, 3)) send_text(octal_char());
      end else if (pick < 72) begin
        send_escape(esd_pkg::CH_X);
        repeat ($urandom_range(0, 3)) send_text(HEX_CHARS[$urandom_range(0, 21)]);
      end else if (pick < 80) begin
        send_escape(any_byte());
      end else if (pick < 87) begin
        send_end();
      end else begin
        send_text(any_byte());
      end
    end
    text_valid <= 1'b0;

    // Drain: wait for every expected byte, then wait on for strays.
    while (expected_left != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (error_count == 0) begin
      $display("escape_sequence_decoder_tb: done, clean");
    end else begin
      $display("escape_sequence_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
